// ===== rtl/ovl_pkg.sv =====
// shared types, codes and constants of the ordered value list
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 5;
   localparam int COUNT_W  = 5;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [FOUND_W-1:0]  found_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam cmd_type CMD_FRONT  = 3'd0;
   localparam cmd_type CMD_BACK   = 3'd1;
   localparam cmd_type CMD_AT     = 3'd2;
   localparam cmd_type CMD_REMOVE = 3'd3;
   localparam cmd_type CMD_FIND   = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_BAD_POS,
      STATUS_FULL,
      STATUS_ABSENT
   } status_type;

   localparam found_type FOUND_NONE = '1;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EVAL,
      FSM_SEARCH,
      FSM_FINISH
   } fsm_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_INSERT,
      OP_DELETE
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       set_status;
      status_type status;
      logic       set_found;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    pos_bad;
      logic    full;
      logic    match_none;
      logic    match_head;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/ovl_if.sv =====
// request and response channel interfaces of the ordered value list
`timescale 1ns / 1ps
`default_nettype none

interface ovl_req_if;
   import ovl_pkg::*;
   logic      valid;
   logic      ready;
   cmd_type   cmd;
   pos_type   position;
   value_type value;
   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

interface ovl_rsp_if;
   import ovl_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   found_type           found_position;
   count_type           entry_count;
   modport source (output valid, output status, output found_position, output entry_count,
                   input ready);
   modport sink (input valid, input status, input found_position, input entry_count,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/ordered_value_list.sv =====
// top level of the ordered value list
//
// Bounded ordered list of CAPACITY unsigned 32-bit values with insert at front,
// back or index, remove of the first equal value and find. One command is in
// work at a time. An insert, a command that finds no match, or an unused
// command passes from acceptance through the evaluate and finish states back
// to idle; a remove or find that matches also passes through the search
// state, which steps through the registered match vector one entry per cycle
// until the match reaches the head. The response sits in an output register,
// so a new command is taken while the previous response still waits; the block
// stalls only if a second response is ready before the first one is taken.
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list #(
   parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ovl_req_if.sink   req_ch,
   ovl_rsp_if.source rsp_ch
);
   import ovl_pkg::*;

   dp_cmd_type          dp_cmd;
   dp_stat_type         dp_stat;
   logic [STATUS_W-1:0] rsp_status;
   found_type           rsp_found_position;
   count_type           rsp_entry_count;

   ovl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   ovl_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_ch.cmd),
      .req_position       (req_ch.position),
      .req_value          (req_ch.value),
      .dp_cmd             (dp_cmd),
      .dp_stat            (dp_stat),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   assign rsp_ch.status         = rsp_status;
   assign rsp_ch.found_position = rsp_found_position;
   assign rsp_ch.entry_count    = rsp_entry_count;

`ifndef SYNTHESIS
   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_INSERT |-> !dp_stat.full && !dp_stat.pos_bad)
      else $error("insert issued on a full list or bad position");

   a_delete_on_match: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_DELETE |-> dp_stat.match_head && dp_stat.cmd == CMD_REMOVE)
      else $error("delete issued without a match");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("second transaction accepted while one is in work");

   a_absent_no_position: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == STATUS_ABSENT |-> rsp_ch.found_position == FOUND_NONE)
      else $error("not-found response carries a position");
`endif

endmodule

`default_nettype wire

// ===== rtl/ovl_ctrl.sv =====
// controller state machine of the ordered value list
`timescale 1ns / 1ps
`default_nettype none

module ovl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ovl_pkg::dp_stat_type dp_stat,
   output ovl_pkg::dp_cmd_type  dp_cmd
);
   import ovl_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          slot_free;
   logic          is_search;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_search = (dp_stat.cmd == CMD_REMOVE) || (dp_stat.cmd == CMD_FIND);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_EVAL;
         end
         FSM_EVAL: begin
            if (is_search && !dp_stat.match_none) state_in = FSM_SEARCH;
            else state_in = FSM_FINISH;
         end
         FSM_SEARCH: begin
            if (dp_stat.match_head) state_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (slot_free) state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dp_cmd    = '{op: OP_NONE, set_status: 1'b0, status: STATUS_OK,
                    set_found: 1'b0, emit: 1'b0};
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) dp_cmd.op = OP_LOAD;
         end
         FSM_EVAL: begin
            unique case (dp_stat.cmd)
               CMD_FRONT, CMD_BACK, CMD_AT: begin
                  if (dp_stat.pos_bad) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = STATUS_BAD_POS;
                  end else if (dp_stat.full) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = STATUS_FULL;
                  end else begin
                     dp_cmd.op = OP_INSERT;
                  end
               end
               CMD_REMOVE: begin
                  if (dp_stat.match_none) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = STATUS_ABSENT;
                  end
               end
               default: begin
               end
            endcase
         end
         FSM_SEARCH: begin
            if (dp_stat.match_head) begin
               if (dp_stat.cmd == CMD_REMOVE) dp_cmd.op = OP_DELETE;
               else dp_cmd.set_found = 1'b1;
            end else begin
               dp_cmd.op = OP_SCAN;
            end
         end
         FSM_FINISH: begin
            dp_cmd.emit = slot_free;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/ovl_dp.sv =====
// datapath of the ordered value list: row of entry cells, match scan, result registers
`timescale 1ns / 1ps
`default_nettype none

module ovl_dp #(
   parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ovl_pkg::cmd_type             req_cmd,
   input  ovl_pkg::pos_type             req_position,
   input  ovl_pkg::value_type           req_value,
   input  ovl_pkg::dp_cmd_type          dp_cmd,
   output ovl_pkg::dp_stat_type         dp_stat,
   output logic [ovl_pkg::STATUS_W-1:0] rsp_status,
   output ovl_pkg::found_type           rsp_found_position,
   output ovl_pkg::count_type           rsp_entry_count
);
   import ovl_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   value_type          cell_ff [CAPACITY];
   value_type          cell_in [CAPACITY];
   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] match_in;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   cmd_type             cmd_ff;
   pos_type             pos_ff;
   value_type           value_ff;
   status_type          res_status_ff;
   found_type           res_found_ff;
   status_type          out_status_ff;
   found_type           out_found_ff;
   count_type           out_count_ff;
   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    ins_at;
   logic [IDX_W+FOUND_W-1:0] idx_wide;
   logic [CNT_W+COUNT_W-1:0] cnt_wide;

   assign cnt_ext  = CMP_W'(count_ff);
   assign pos_ext  = CMP_W'(pos_ff);
   assign idx_wide = {FOUND_W'(0), idx_ff};
   assign cnt_wide = {COUNT_W'(0), count_ff};

   always_comb begin
      unique case (cmd_ff)
         CMD_FRONT: ins_at = '0;
         CMD_BACK:  ins_at = cnt_ext;
         default:   ins_at = pos_ext;
      endcase
   end

   genvar g;
   for (g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int LOWER = (g == 0) ? 0 : g - 1;
      localparam int UPPER = (g == CAPACITY - 1) ? g : g + 1;
      localparam logic [CMP_W-1:0] G_POS = CMP_W'(g);
      localparam logic [IDX_W-1:0] G_IDX = IDX_W'(g);

      assign hit[g] = (cell_ff[g] == req_value) && (G_POS < cnt_ext);

      always_comb begin
         cell_in[g] = cell_ff[g];
         if (dp_cmd.op == OP_INSERT) begin
            if (G_POS == ins_at) cell_in[g] = value_ff;
            else if (G_POS > ins_at) cell_in[g] = cell_ff[LOWER];
         end else if (dp_cmd.op == OP_DELETE) begin
            if (G_IDX >= idx_ff) cell_in[g] = cell_ff[UPPER];
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[g] <= cell_in[g];
      end
   end

   always_comb begin
      match_in = match_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      unique case (dp_cmd.op)
         OP_LOAD: begin
            match_in = hit;
            idx_in   = '0;
         end
         OP_SCAN: begin
            match_in = match_ff >> 1;
            idx_in   = idx_ff + IDX_W'(1);
         end
         OP_INSERT: count_in = count_ff + CNT_W'(1);
         OP_DELETE: count_in = count_ff - CNT_W'(1);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      idx_ff   <= idx_in;
      if (dp_cmd.op == OP_LOAD) begin
         cmd_ff        <= req_cmd;
         pos_ff        <= req_position;
         value_ff      <= req_value;
         res_status_ff <= STATUS_OK;
         res_found_ff  <= FOUND_NONE;
      end
      if (dp_cmd.set_status) res_status_ff <= dp_cmd.status;
      if (dp_cmd.set_found) res_found_ff <= idx_wide[FOUND_W-1:0];
      if (dp_cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_found_ff  <= res_found_ff;
         out_count_ff  <= cnt_wide[COUNT_W-1:0];
      end
   end

   assign dp_stat.cmd        = cmd_ff;
   assign dp_stat.pos_bad    = (cmd_ff == CMD_AT) && (pos_ext > cnt_ext);
   assign dp_stat.full       = count_ff >= CNT_W'(CAPACITY);
   assign dp_stat.match_none = (match_ff == '0);
   assign dp_stat.match_head = match_ff[0];

   assign rsp_status         = out_status_ff;
   assign rsp_found_position = out_found_ff;
   assign rsp_entry_count    = out_count_ff;

endmodule

`default_nettype wire
